@@ sv/sit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;
    localparam int BUCKET_COUNT_DEF = 256;
    localparam int NAME_CHARS_DEF   = 32;
    localparam int ENTRY_COUNT_DEF  = 1024;
    localparam int HASH_MUL         = 101;
    localparam int ID_W             = 10;
    localparam int CHAR_W           = 8;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0] entry_id;
        logic [1:0]      status;
    } result_t;
endpackage
`default_nettype wire

@@ sv/sit_name_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// collects one name: running hash, length, overlong flag, and byte store
module sit_name_buf #(
    parameter int BUCKET_COUNT = sit_pkg::BUCKET_COUNT_DEF,
    parameter int NAME_CHARS   = sit_pkg::NAME_CHARS_DEF,
    localparam int HW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1,
    localparam int LW = $clog2(NAME_CHARS + 1),
    localparam int CW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr,
    input  wire logic [sit_pkg::CHAR_W-1:0] wr_char,
    input  wire logic                      clear,
    input  wire logic [CW-1:0]             rd_addr,
    output logic [sit_pkg::CHAR_W-1:0]     rd_char,
    output logic [HW-1:0]                  hash,
    output logic [LW-1:0]                  length,
    output logic                           overlong
);
    logic [sit_pkg::CHAR_W-1:0] mem [NAME_CHARS];
    logic [HW-1:0] hash_reg, hash_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovl_reg, ovl_next;
    logic [HW-1:0] prod;

    // only the low bits of the hash survive the mask, so work at that width
    assign prod = HW'(hash_reg * HW'(sit_pkg::HASH_MUL)) + HW'(wr_char);

    always_comb
    begin
        hash_next = hash_reg;
        len_next  = len_reg;
        ovl_next  = ovl_reg;
        if (clear)
        begin
            hash_next = '0;
            len_next  = '0;
            ovl_next  = 1'b0;
        end
        else if (wr)
        begin
            hash_next = prod;
            if (len_reg < LW'(NAME_CHARS))
                len_next = len_reg + 1'b1;
            else
                ovl_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            len_reg  <= '0;
            ovl_reg  <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
            ovl_reg  <= ovl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !clear && len_reg < LW'(NAME_CHARS))
            mem[len_reg[CW-1:0]] <= wr_char;
        rd_char <= mem[rd_addr];
    end

    assign hash     = hash_reg;
    assign length   = len_reg;
    assign overlong = ovl_reg;
endmodule
`default_nettype wire

@@ sv/sit_pool.sv @@
`timescale 1ns / 1ps
`default_nettype none
// entry pool memories and bucket head memory, registered reads
module sit_pool #(
    parameter int BUCKET_COUNT = sit_pkg::BUCKET_COUNT_DEF,
    parameter int NAME_CHARS   = sit_pkg::NAME_CHARS_DEF,
    parameter int ENTRY_COUNT  = sit_pkg::ENTRY_COUNT_DEF,
    localparam int HW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1,
    localparam int LW = $clog2(NAME_CHARS + 1),
    localparam int CW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1,
    localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // bucket heads
    input  wire logic [HW-1:0]             head_addr,
    input  wire logic                      head_we,
    input  wire logic [EW-1:0]             head_wdata,
    output logic                           head_valid,
    output logic [EW-1:0]                  head_id,
    // chars
    input  wire logic [EW-1:0]             ch_entry,
    input  wire logic [CW-1:0]             ch_idx,
    input  wire logic                      ch_we,
    input  wire logic [sit_pkg::CHAR_W-1:0] ch_wdata,
    output logic [sit_pkg::CHAR_W-1:0]     ch_rdata,
    // lengths and links
    input  wire logic [EW-1:0]             ent_addr,
    input  wire logic                      len_we,
    input  wire logic [LW-1:0]             len_wdata,
    output logic [LW-1:0]                  len_rdata,
    input  wire logic                      link_we,
    input  wire logic [EW:0]               link_wdata,
    output logic [EW:0]                    link_rdata
);
    logic [sit_pkg::CHAR_W-1:0] chars [ENTRY_COUNT*NAME_CHARS];
    logic [LW-1:0]              lens  [ENTRY_COUNT];
    logic [EW:0]                links [ENTRY_COUNT];
    logic [EW-1:0]              heads [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0]    hvalid_reg;
    logic [$clog2(ENTRY_COUNT*NAME_CHARS)-1:0] ch_addr;

    assign ch_addr = $bits(ch_addr)'(ch_entry * NAME_CHARS + ch_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            head_valid <= 1'b0;
        end
        else
        begin
            if (head_we)
                hvalid_reg[head_addr] <= 1'b1;
            head_valid <= hvalid_reg[head_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            heads[head_addr] <= head_wdata;
        head_id <= heads[head_addr];
        if (ch_we)
            chars[ch_addr] <= ch_wdata;
        ch_rdata <= chars[ch_addr];
        if (len_we)
            lens[ent_addr] <= len_wdata;
        len_rdata <= lens[ent_addr];
        if (link_we)
            links[ent_addr] <= link_wdata;
        link_rdata <= links[ent_addr];
    end
endmodule
`default_nettype wire

@@ sv/string_intern_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Interns names arriving one character per request (tlast on the final one).
// A plain character is taken while the core is idle, also while an earlier
// result still waits at the output. The final character starts the lookup and
// the input stays stalled until the result is handed to the output register:
// the bucket head is read, then per chain entry the stored length is read and,
// when it matches, the characters are compared one by one up to a hit or a
// mismatch. An insert copies the L characters, writes the length and link and
// links behind any chain tail; the hand-off waits for a free output register.
// One result per name; too long or pool full is reported in status with
// entry_id 0. Bucket valid bits clear at reset, no sweep.
module string_intern_table_core #(
    parameter int BUCKET_COUNT = sit_pkg::BUCKET_COUNT_DEF,
    parameter int NAME_CHARS   = sit_pkg::NAME_CHARS_DEF,
    parameter int ENTRY_COUNT  = sit_pkg::ENTRY_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // character
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // entry_id[9:0], status[11:10], zero
);
    localparam int HW  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int LW  = $clog2(NAME_CHARS + 1);
    localparam int CW  = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int EW  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int NW  = $clog2(ENTRY_COUNT + 1);
    localparam int IDW = sit_pkg::ID_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HEAD  = 4'd1;
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_LEN   = 4'd3;
    localparam logic [3:0] S_LWAIT = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_CWAIT = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_RWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_LINK  = 4'd10;

    logic [3:0]  st_reg, st_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] tail_reg, tail_next;
    logic        htail_reg, htail_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [NW-1:0] free_reg, free_next;
    sit_pkg::result_t ans_reg, ans_next;
    sit_pkg::result_t res_reg, res_next;
    logic        ovalid_reg, ovalid_next;

    logic        acc;
    logic [sit_pkg::CHAR_W-1:0] nb_char;
    logic [HW-1:0] hash;
    logic [LW-1:0] length;
    logic          overlong;
    logic          nb_clear;

    logic          head_we, head_valid, ch_we, len_we, link_we;
    logic [EW-1:0] head_wdata, head_id, ent_addr, ch_entry;
    logic [CW-1:0] ch_idx;
    logic [LW-1:0] len_rdata;
    logic [EW:0]   link_wdata, link_rdata;
    logic [sit_pkg::CHAR_W-1:0] ch_rdata;
    logic [EW-1:0] new_id;

    assign new_id = free_reg[EW-1:0];
    assign s_axis_tready = (st_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {4'b0, res_reg.status, res_reg.entry_id};
    // during the copy the name buffer reads one ahead of the pool write
    assign ch_idx = (st_reg == S_INS) ? idx_reg[CW-1:0] : idx_next[CW-1:0];

    sit_name_buf #(.BUCKET_COUNT(BUCKET_COUNT), .NAME_CHARS(NAME_CHARS)) u_nb (
        .clk, .rst_n, .wr(acc), .wr_char(s_axis_tdata), .clear(nb_clear),
        .rd_addr(idx_next[CW-1:0]), .rd_char(nb_char),
        .hash, .length, .overlong
    );

    sit_pool #(.BUCKET_COUNT(BUCKET_COUNT), .NAME_CHARS(NAME_CHARS),
               .ENTRY_COUNT(ENTRY_COUNT)) u_pool (
        .clk, .rst_n,
        .head_addr(hash), .head_we, .head_wdata, .head_valid, .head_id,
        .ch_entry, .ch_idx, .ch_we, .ch_wdata(nb_char),
        .ch_rdata, .ent_addr, .len_we, .len_wdata(length), .len_rdata,
        .link_we, .link_wdata, .link_rdata
    );

    always_comb
    begin
        st_next     = st_reg;
        cur_next    = cur_reg;
        tail_next   = tail_reg;
        htail_next  = htail_reg;
        idx_next    = idx_reg;
        free_next   = free_reg;
        ans_next    = ans_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        nb_clear    = 1'b0;
        head_we     = 1'b0;
        head_wdata  = new_id;
        ch_we       = 1'b0;
        len_we      = 1'b0;
        link_we     = 1'b0;
        link_wdata  = {1'b1, new_id};
        ent_addr    = cur_reg;
        ch_entry    = cur_reg;
        case (st_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (acc && s_axis_tlast)
                    st_next = S_HEAD;
            end
            S_HEAD:
            begin
                htail_next = 1'b0;
                if (overlong)
                begin
                    ans_next.entry_id = '0;
                    ans_next.status   = sit_pkg::ST_TOO_LONG;
                    st_next = S_OUT;
                end
                else
                    st_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (head_valid)
                begin
                    cur_next = head_id;
                    st_next = S_LEN;
                end
                else
                begin
                    idx_next = '0;
                    st_next = S_INS;
                end
            end
            S_LEN:
            begin
                idx_next = '0;
                st_next = S_LWAIT;
            end
            S_LWAIT:
                st_next = (len_rdata == length) ? S_CMP : S_CWAIT;
            S_CMP:
            begin
                // chars at idx_reg, read in the state before, sit at both memory outputs now
                if (idx_reg == length)
                begin
                    ans_next.entry_id = IDW'(cur_reg);
                    ans_next.status   = sit_pkg::ST_FOUND;
                    st_next = S_OUT;
                end
                else if (ch_rdata != nb_char)
                    st_next = S_CWAIT;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    st_next = S_RWAIT;
                end
            end
            S_RWAIT:
                st_next = S_CMP;
            S_CWAIT:
            begin
                // link of cur was read during the length check
                tail_next = cur_reg;
                htail_next = 1'b1;
                if (link_rdata[EW])
                begin
                    cur_next = link_rdata[EW-1:0];
                    st_next = S_LEN;
                end
                else
                begin
                    idx_next = '0;
                    st_next = S_INS;
                end
            end
            S_INS:
            begin
                ch_entry = new_id;
                ent_addr = new_id;
                if (free_reg >= NW'(ENTRY_COUNT))
                begin
                    ans_next.entry_id = '0;
                    ans_next.status   = sit_pkg::ST_FULL;
                    st_next = S_OUT;
                end
                else if (idx_reg != length)
                begin
                    ch_we = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    len_we = 1'b1;
                    link_we = 1'b1;
                    link_wdata = '0;
                    ans_next.entry_id = IDW'(new_id);
                    ans_next.status   = sit_pkg::ST_INSERTED;
                    if (htail_reg)
                        st_next = S_LINK;
                    else
                    begin
                        head_we = 1'b1;
                        free_next = free_reg + 1'b1;
                        st_next = S_OUT;
                    end
                end
            end
            S_LINK:
            begin
                // append behind the chain tail
                ent_addr = tail_reg;
                link_we = 1'b1;
                link_wdata = {1'b1, new_id};
                free_next = free_reg + 1'b1;
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    res_next = ans_reg;
                    ovalid_next = 1'b1;
                    nb_clear = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            free_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            free_reg   <= free_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        tail_reg  <= tail_next;
        htail_reg <= htail_next;
        idx_reg   <= idx_next;
        ans_reg   <= ans_next;
        res_reg   <= res_next;
    end
endmodule
`default_nettype wire

@@ test/string_intern_table_core_tb.sv @@
`timescale 1ns / 1ps
module string_intern_table_core_tb;
    localparam int BUCKETS = sit_pkg::BUCKET_COUNT_DEF;
    localparam int MAX_LEN = sit_pkg::NAME_CHARS_DEF;
    localparam int POOL    = sit_pkg::ENTRY_COUNT_DEF;

    typedef logic [7:0] name_t[$];

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // character
    logic        s_axis_tlast;   // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // entry_id[9:0], status[11:10], zero

    string_intern_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // shadow of the intern table
    int unsigned  cur_hash;
    logic [7:0]   cur_chars[MAX_LEN];
    int unsigned  cur_len;
    bit           cur_overlong;
    bit           head_valid[BUCKETS];
    int unsigned  head_id[BUCKETS];
    logic [7:0]   pool_chars[POOL][MAX_LEN];
    int unsigned  pool_len[POOL];
    bit           link_valid[POOL];
    int unsigned  link_id[POOL];
    int unsigned  next_id;

    sit_pkg::result_t lookup_q[$];
    name_t        known_names[$];
    int           errors;
    int           items_sent;
    int           burst_left;
    int           rx_mode;
    bit           hold_start;
    int           hold_left;

    function automatic bit same_name(int unsigned id);
        if (pool_len[id] != cur_len)
            return 1'b0;
        for (int i = 0; i < cur_len; i++)
            if (pool_chars[id][i] != cur_chars[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic intern_char(input logic [7:0] c, input bit fin);
        int unsigned bkt;
        int unsigned cur;
        int unsigned tail;
        bit          walking;
        bit          has_tail;
        bit          done;
        sit_pkg::result_t r;
        cur_hash = (cur_hash * sit_pkg::HASH_MUL + c) % BUCKETS;
        if (cur_len < MAX_LEN)
        begin
            cur_chars[cur_len] = c;
            cur_len++;
        end
        else
            cur_overlong = 1'b1;
        if (!fin)
            return;
        done = 1'b0;
        if (cur_overlong)
        begin
            r.entry_id = '0;
            r.status = sit_pkg::ST_TOO_LONG;
            done = 1'b1;
        end
        else
        begin
            bkt = cur_hash;
            walking = head_valid[bkt];
            cur = head_id[bkt];
            has_tail = 1'b0;
            tail = 0;
            for (int s = 0; s < POOL && walking && !done; s++)
            begin
                if (same_name(cur))
                begin
                    r.entry_id = cur[sit_pkg::ID_W-1:0];
                    r.status = sit_pkg::ST_FOUND;
                    done = 1'b1;
                end
                else
                begin
                    tail = cur;
                    has_tail = 1'b1;
                    walking = link_valid[cur];
                    cur = link_id[cur];
                end
            end
            if (!done && next_id >= POOL)
            begin
                r.entry_id = '0;
                r.status = sit_pkg::ST_FULL;
                done = 1'b1;
            end
            if (!done)
            begin
                for (int i = 0; i < cur_len; i++)
                    pool_chars[next_id][i] = cur_chars[i];
                pool_len[next_id] = cur_len;
                link_valid[next_id] = 1'b0;
                if (has_tail)
                begin
                    link_valid[tail] = 1'b1;
                    link_id[tail] = next_id;
                end
                else
                begin
                    head_valid[bkt] = 1'b1;
                    head_id[bkt] = next_id;
                end
                r.entry_id = next_id[sit_pkg::ID_W-1:0];
                r.status = sit_pkg::ST_INSERTED;
                next_id++;
            end
        end
        lookup_q.push_back(r);
        cur_hash = 0;
        cur_len = 0;
        cur_overlong = 1'b0;
    endtask

    task automatic send_char(input logic [7:0] c, input bit fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        intern_char(c, fin);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_name(input name_t nm);
        for (int i = 0; i < nm.size(); i++)
            send_char(nm[i], i == nm.size() - 1);
        known_names.push_back(nm);
    endtask

    function automatic name_t one_char(input logic [7:0] c0);
        name_t nm;
        nm.push_back(c0);
        return nm;
    endfunction

    function automatic name_t two_chars(input logic [7:0] c0, input logic [7:0] c1);
        name_t nm;
        nm.push_back(c0);
        nm.push_back(c1);
        return nm;
    endfunction

    function automatic name_t random_name(int lo, int hi);
        name_t nm;
        int    n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            nm.push_back(8'($urandom_range(0, 255)));
        return nm;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic test_directed();
        send_name(one_char(8'h01));
        send_name(one_char(8'hFF));
        send_name(one_char(8'h00));
        send_name(one_char(8'h01));
        // same bucket as the single 8'h05, so the chain grows
        send_name(one_char(8'h05));
        send_name(two_chars(8'h01, 8'd160));
        send_name(one_char(8'h05));
        send_name(two_chars(8'h01, 8'd160));
        send_name(two_chars(8'h00, 8'hFF));
        send_name(one_char(8'hFF));
        drain();
    endtask

    task automatic test_lengths();
        name_t nm;
        rx_mode = 1;
        nm.delete();
        for (int i = 0; i < MAX_LEN; i++)
            nm.push_back(8'hFF);
        send_name(nm);
        send_name(nm);
        nm.push_back(8'hFF);
        send_name(nm);
        void'(nm.pop_back());
        void'(nm.pop_back());
        nm.push_back(8'hFE);
        send_name(nm);
        send_name(nm);
        drain();
        rx_mode = 0;
    endtask

    task automatic test_random();
        int pick;
        int start;
        bit hold_done;
        start = items_sent;
        hold_done = 1'b0;
        while (items_sent - start < 680)
        begin
            if (!hold_done && items_sent - start > 300)
            begin
                hold_start = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent - start > 500)
                rx_mode = 2;
            pick = $urandom_range(0, 99);
            if (pick < 45 && known_names.size() != 0)
                send_name(known_names[$urandom_range(0, known_names.size() - 1)]);
            else if (pick < 85)
                send_name(random_name(1, 6));
            else if (pick < 95)
                send_name(random_name(7, MAX_LEN));
            else
                send_name(random_name(MAX_LEN + 1, MAX_LEN + 8));
        end
        drain();
    endtask

    // result port stall patterns
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = 300;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_mode == 0)
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        else if (rx_mode == 1)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 7) < 2);
    end

    always @(posedge clk)
    begin
        sit_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (lookup_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                want = lookup_q.pop_front();
                if (m_axis_tdata[9:0] != want.entry_id)
                begin
                    $display("%0t entry_id: expected %0d, actual %0d", $time,
                             want.entry_id, m_axis_tdata[9:0]);
                    errors++;
                end
                if (m_axis_tdata[11:10] != want.status)
                begin
                    $display("%0t status: expected %0d, actual %0d", $time,
                             want.status, m_axis_tdata[11:10]);
                    errors++;
                end
                if (m_axis_tdata[15:12] != 4'd0)
                begin
                    $display("%0t pad bits: expected 0, actual %h", $time,
                             m_axis_tdata[15:12]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        rx_mode = 0;
        hold_start = 1'b0;
        hold_left = 0;
        cur_hash = 0;
        cur_len = 0;
        cur_overlong = 1'b0;
        next_id = 0;
        for (int b = 0; b < BUCKETS; b++)
            head_valid[b] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_lengths();
        test_random();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
